FILE: sv/mtf_pkg.sv
// Shared types, constants and helpers for the move-to-front rank encoder.
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int ITEM_W    = 9;
    localparam int RANK_W    = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [ADDR_W-1:0] ADDR_ITEM_COUNT  = '0;
    localparam logic [ITEM_W-1:0] ITEM_COUNT_RESET = 9'd256;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic init;    // reload identity order
        logic shift;   // move entries up to pos one place back
        idx_t pos;     // position of the requested item
        idx_t target;  // requested item, zero based
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC,
        ST_MOVE
    } state_t;

    function automatic logic [RANK_W-1:0] sat_rank(input idx_t pos);
        if (int'(pos) > (2 ** RANK_W) - 1) begin
            return '1;
        end
        return RANK_W'(pos);
    endfunction

endpackage

FILE: sv/move_to_front_rank_encoder_core.sv
// Move-to-front rank encoder: a row of list cells, a hit encoder and the control.
`timescale 1ns / 1ps

// Keeps the order of items 1..item_count in a row of cells, one cell per list
// position. For each word on the input stream the block returns the 0-based
// rank of item_id and then moves that item to the front. A set restart flag
// puts the order back to 1..item_count before the item is handled, and so
// does any write of item_count. An item of 0 or above item_count (taken as 1
// when zero, at most 256) returns rank 0 with the bad flag and leaves the
// order alone. Each item goes through accept, compare in every cell, encode
// the hit position (held while the output is full) and shift the cells in
// front of the hit. The next item is accepted while a finished result waits.
module move_to_front_rank_encoder_core
    import mtf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [8:0] item_id, [15:9] zero
    input  logic              s_tuser,   // [0] restart
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] rank
    output logic              m_tuser,   // [0] bad_item
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    state_t              state_reg, state_next;
    logic [ITEM_W-1:0]   item_count_reg;
    logic [ITEM_W-1:0]   eff_count;
    idx_t                target_reg;
    logic                bad_reg;
    idx_t                pos_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [RANK_W-1:0]   rank_reg;
    logic                bad_out_reg;
    logic                load_out;
    logic                cfg_wr;
    logic                accept;
    logic [ITEM_W-1:0]   item_id;
    idx_t                enc_pos;
    cell_ctrl_t          ctrl;
    idx_t                vals [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] hits;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_ITEM_COUNT);
    assign prdata   = (paddr == ADDR_ITEM_COUNT) ? DATA_W'(item_count_reg) : '0;

    assign item_id  = s_tdata[ITEM_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (item_count_reg == '0) begin
            eff_count = ITEM_W'(1);
        end else if (int'(item_count_reg) > MAX_ITEMS) begin
            eff_count = ITEM_W'(MAX_ITEMS);
        end else begin
            eff_count = item_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= ITEM_COUNT_RESET;
        end else if (cfg_wr) begin
            item_count_reg <= pwdata[ITEM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            target_reg <= IDX_W'(item_id - ITEM_W'(1));
            bad_reg    <= (item_id == '0) || (item_id > eff_count);
        end
        if (load_out) begin
            pos_reg     <= enc_pos;
            rank_reg    <= bad_reg ? '0 : sat_rank(enc_pos);
            bad_out_reg <= bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_ENC;
            end
            ST_ENC: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_MOVE;
                end
            end
            ST_MOVE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ctrl.init   = (accept && s_tuser) || cfg_wr;
    assign ctrl.shift  = (state_reg == ST_MOVE) && !bad_reg;
    assign ctrl.pos    = pos_reg;
    assign ctrl.target = target_reg;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        idx_t prev_val;
        if (k == 0) begin : g_front
            // the front cell takes the requested item
            assign prev_val = target_reg;
        end else begin : g_rest
            assign prev_val = vals[k-1];
        end
        mtf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(k)),
            .prev_val (prev_val),
            .ctrl     (ctrl),
            .val      (vals[k]),
            .hit      (hits[k])
        );
    end

    mtf_enc u_enc (
        .hit (hits),
        .pos (enc_pos)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rank_reg;
    assign m_tuser  = bad_out_reg;

endmodule

FILE: sv/mtf_cell.sv
// One entry of the order list: holds an item, compares it, takes its neighbor's item on a move.
`timescale 1ns / 1ps

module mtf_cell
    import mtf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  idx_t       cell_idx,
    input  idx_t       prev_val,
    input  cell_ctrl_t ctrl,
    output idx_t       val,
    output logic       hit
);

    idx_t val_reg;
    logic hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.init) begin
            val_reg <= cell_idx;
        end else if (ctrl.shift && (cell_idx <= ctrl.pos)) begin
            val_reg <= prev_val;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= (val_reg == ctrl.target);
    end

    assign val = val_reg;
    assign hit = hit_reg;

endmodule

FILE: sv/mtf_enc.sv
// One-hot to binary encoder for the cell hit flags.
`timescale 1ns / 1ps

module mtf_enc
    import mtf_pkg::*;
(
    input  logic [MAX_ITEMS-1:0] hit,
    output idx_t                 pos
);

    // Exactly one cell matches a valid item, so a plain OR per bit suffices.
    always_comb begin
        pos = '0;
        for (int b = 0; b < IDX_W; b++) begin
            for (int k = 0; k < MAX_ITEMS; k++) begin
                if (hit[k] && (((k >> b) & 1) == 1)) begin
                    pos[b] = 1'b1;
                end
            end
        end
    end

endmodule

FILE: test/tb_move_to_front_rank_encoder_core.sv
// Testbench for the move-to-front rank encoder: stream stimulus, APB writes, rank checks.
`timescale 1ns / 1ps

module tb_move_to_front_rank_encoder_core;
    import mtf_pkg::*;

    // address 4 of the register map holds nothing; writes there must be ignored
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              bad;
    } rank_word_t;

    // Tracks the item order and the ranks still owed by the block.
    class rank_scoreboard;
        idx_t             lineup[MAX_ITEMS];
        logic [ITEM_W-1:0] item_count;
        rank_word_t       expected_ranks[$];
        int               errors;

        function new();
            item_count = ITEM_COUNT_RESET;
            errors     = 0;
            restore_identity();
        endfunction

        function void restore_identity();
            for (int k = 0; k < MAX_ITEMS; k++) begin
                lineup[k] = idx_t'(k);
            end
        endfunction

        function int live_count();
            if (item_count == 0) begin
                return 1;
            end
            if (int'(item_count) > MAX_ITEMS) begin
                return MAX_ITEMS;
            end
            return int'(item_count);
        endfunction

        function void apply_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            if (addr == ADDR_ITEM_COUNT) begin
                item_count = data[ITEM_W-1:0];
                restore_identity();
            end
        endfunction

        function void accept_item(logic [ITEM_W-1:0] id, logic restart);
            int         cnt;
            int         pos;
            rank_word_t want;
            cnt       = live_count();
            want.rank = '0;
            want.bad  = 1'b1;
            if (restart) begin
                restore_identity();
            end
            if (id != 0 && int'(id) <= cnt) begin
                pos = -1;
                for (int k = 0; k < cnt; k++) begin
                    if (pos < 0 && lineup[k] == idx_t'(id - 1)) begin
                        pos = k;
                    end
                end
                if (pos >= 0) begin
                    for (int k = pos; k > 0; k--) begin
                        lineup[k] = lineup[k-1];
                    end
                    lineup[0] = idx_t'(id - 1);
                    want.rank = (pos > 255) ? 8'hFF : 8'(pos);
                    want.bad  = 1'b0;
                end
            end
            expected_ranks.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_rank(logic [RANK_W-1:0] rank, logic bad);
            rank_word_t want;
            if (expected_ranks.size() == 0) begin
                report($sformatf("unexpected word rank=%0d bad=%0b", rank, bad));
            end else begin
                want = expected_ranks.pop_front();
                if (rank !== want.rank) begin
                    report($sformatf("rank got %0d want %0d", rank, want.rank));
                end
                if (bad !== want.bad) begin
                    report($sformatf("bad_item got %0b want %0b", bad, want.bad));
                end
            end
        endtask

        function int outstanding();
            return expected_ranks.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [8:0] item_id, [15:9] zero
    logic              s_tuser;   // [0] restart
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // [7:0] rank
    logic              m_tuser;   // [0] bad_item
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rank_scoreboard sb;
    bit             steady;
    bit             hold_request;
    int             hold_left;
    int             cur_count;
    int             recent_ids[$];

    move_to_front_rank_encoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls unless steady, one long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 36);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_rank(m_tdata, m_tuser);
        end
    end

    task send_word(int id, bit restart);
        if (!steady) begin
            while ($urandom_range(0, 99) < 36) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, 9'(id)};
        s_tuser  <= restart;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.accept_item(9'(id), restart);
        if (id >= 1 && id <= cur_count) begin
            recent_ids.push_back(id);
            if (recent_ids.size() > 6) begin
                void'(recent_ids.pop_front());
            end
        end
    endtask

    task end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task drain();
        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        sb.apply_write(addr, data);
        if (addr == ADDR_ITEM_COUNT) begin
            cur_count = sb.live_count();
            recent_ids.delete();
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly legal ids, some repeats of recent ones, some out of range
    task send_random(int n);
        int  roll;
        int  id;
        bit  restart;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                id = $urandom_range(0, 511);
            end else if (roll < 25 && recent_ids.size() > 0) begin
                id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
            end else begin
                id = $urandom_range(1, cur_count);
            end
            restart = ($urandom_range(0, 99) < 4);
            send_word(id, restart);
        end
    endtask

    initial begin
        int cfg_vals[9];
        int cfg_items[9];

        cfg_vals     = '{1, 0, 2, 511, 3, 16, 256, 100, 37};
        cfg_items    = '{20, 20, 60, 90, 70, 110, 140, 90, 50};
        sb           = new();
        steady       = 1'b0;
        hold_request = 1'b0;
        cur_count    = sb.live_count();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset order, full list
        send_word(256, 1'b0);
        send_word(256, 1'b0);
        send_word(1, 1'b0);
        send_word(0, 1'b0);
        send_word(257, 1'b0);
        send_word(511, 1'b0);
        send_word(128, 1'b1);
        send_word(300, 1'b1);
        send_word(1, 1'b0);
        send_word(2, 1'b0);
        send_random(100);
        end_burst();
        drain();

        // writes to the empty slot must not disturb the order
        apb_write(ADDR_UNUSED, 32'd5);
        send_word(2, 1'b0);
        end_burst();
        drain();

        for (int p = 0; p < 9; p++) begin
            apb_write(ADDR_ITEM_COUNT, DATA_W'(cfg_vals[p]));
            steady = (cfg_vals[p] == 256);
            send_word(cur_count, 1'b0);
            send_word(cur_count + 1, 1'b0);
            send_word(1, 1'b1);
            if (cfg_vals[p] == 16) begin
                // stop taking results and keep offering words
                send_random(10);
                hold_request = 1'b1;
                send_random(cfg_items[p] - 10);
            end else if (cfg_vals[p] == 511) begin
                send_random(cfg_items[p] / 2);
                end_burst();
                drain();
                send_random(cfg_items[p] - cfg_items[p] / 2);
            end else begin
                send_random(cfg_items[p]);
            end
            end_burst();
            drain();
            steady = 1'b0;
        end

        repeat (20) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            sb.report($sformatf("%0d ranks never arrived", sb.outstanding()));
        end
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/mtf_pkg.sv
sv/mtf_cell.sv
sv/mtf_enc.sv
sv/move_to_front_rank_encoder_core.sv
test/tb_move_to_front_rank_encoder_core.sv
